// File: rtl/lsi_pkg.sv
`default_nettype none
package lsi_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 22;
    localparam int IO_WIDTH          = 32;
    localparam int DT_WIDTH          = 23;
    localparam int CFG_INDEX_WIDTH   = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIGMA  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RHO    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BETA   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DT     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_METHOD = 3'd4;

    localparam logic [IO_WIDTH-1:0] SIGMA_RESET = 32'd41943040;
    localparam logic [IO_WIDTH-1:0] RHO_RESET   = 32'd117440512;
    localparam logic [IO_WIDTH-1:0] BETA_RESET  = 32'd11184810;
    localparam logic [DT_WIDTH-1:0] DT_RESET    = 23'd41943;

    // ALU operations
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV6
    } alu_op_t;

endpackage
`default_nettype wire

// File: rtl/lorenz_system_integrator_unit.sv
`default_nettype none
// Lorenz system integrator, Q10.22 fixed point.
// Channels: input word (mode, x_in, y_in, z_in) on in_valid/in_ready;
// result word (x_out, y_out, z_out, step_count) on out_valid/out_ready;
// configuration writes (cfg_index, cfg_data) on cfg_valid/cfg_ready.
// mode 0 loads the state and clears the step count; mode 1 advances by dt.
// All arithmetic runs through one shared saturating ALU under a microcode
// sequencer; each operation passes an issue state, then a writeback state.
// From input accept to out_valid: a load goes straight to the output state;
// an Euler step runs 14 ops and an RK4 step 78 ops, then the output state;
// the op count of the selected method sets the rate. in_ready is low while
// a word is in work and while the result word waits, so a new word is
// taken only after the result of the last one has been taken.
// The result sits in an output register; a stalled receiver holds it there
// and keeps in_ready low until it is taken.
// Reset: sigma 10, rho 28, beta 8/3, dt about 0.01, method RK4, state zero.
module lorenz_system_integrator_unit #(
    parameter int VALUE_WIDTH   = lsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = lsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  mode,
    input  wire logic signed [lsi_pkg::IO_WIDTH-1:0] x_in,
    input  wire logic signed [lsi_pkg::IO_WIDTH-1:0] y_in,
    input  wire logic signed [lsi_pkg::IO_WIDTH-1:0] z_in,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic signed [lsi_pkg::IO_WIDTH-1:0]  x_out,
    output logic signed [lsi_pkg::IO_WIDTH-1:0]  y_out,
    output logic signed [lsi_pkg::IO_WIDTH-1:0]  z_out,
    output logic [lsi_pkg::IO_WIDTH-1:0]         step_count,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [lsi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire  [lsi_pkg::IO_WIDTH-1:0]         cfg_data
);
    import lsi_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // register file slots
    typedef enum logic [4:0] {
        R_X, R_Y, R_Z, R_SIG, R_RHO, R_BETA, R_DT, R_H,
        R_AX, R_AY, R_AZ, R_T0, R_T1,
        R_KX, R_KY, R_KZ, R_SX, R_SY, R_SZ
    } slot_t;

    typedef struct packed {
        alu_op_t op;
        slot_t   sa;
        slot_t   sb;
        slot_t   dst;
    } uop_t;

    localparam int NREG = 19;
    localparam int EULER_LEN = 14;
    localparam int RK_LEN = 78;
    localparam int PCW = 7;

    function automatic logic signed [W-1:0] sat_in(input logic [IO_WIDTH-1:0] v);
        logic signed [IO_WIDTH:0] s;
        s = {v[IO_WIDTH-1], v};
        if (W >= IO_WIDTH + 1)
            return W'(s);
        else if (s > (IO_WIDTH+1)'(VMAX))
            return VMAX;
        else if (s < (IO_WIDTH+1)'(VMIN))
            return VMIN;
        else
            return W'(s);
    endfunction

    function automatic uop_t mk(input alu_op_t o, input slot_t a, input slot_t b,
                                input slot_t d);
        mk = '{op: o, sa: a, sb: b, dst: d};
    endfunction

    // derivative of (px,py,pz) into (kx,ky,kz)
    function automatic uop_t deriv(input int i, input slot_t px, input slot_t py,
                                   input slot_t pz);
        case (i)
            0:       deriv = mk(OP_SUB, py, px, R_T0);
            1:       deriv = mk(OP_MUL, R_SIG, R_T0, R_KX);
            2:       deriv = mk(OP_SUB, R_RHO, pz, R_T0);
            3:       deriv = mk(OP_MUL, px, R_T0, R_T0);
            4:       deriv = mk(OP_SUB, R_T0, py, R_KY);
            5:       deriv = mk(OP_MUL, px, py, R_T0);
            6:       deriv = mk(OP_MUL, R_BETA, pz, R_T1);
            default: deriv = mk(OP_SUB, R_T0, R_T1, R_KZ);
        endcase
    endfunction

    // midpoint: a = state + f*k
    function automatic uop_t midpt(input int i, input slot_t f);
        case (i)
            0:       midpt = mk(OP_MUL, f, R_KX, R_T0);
            1:       midpt = mk(OP_ADD, R_X, R_T0, R_AX);
            2:       midpt = mk(OP_MUL, f, R_KY, R_T0);
            3:       midpt = mk(OP_ADD, R_Y, R_T0, R_AY);
            4:       midpt = mk(OP_MUL, f, R_KZ, R_T0);
            default: midpt = mk(OP_ADD, R_Z, R_T0, R_AZ);
        endcase
    endfunction

    // accumulate weighted k into S
    function automatic uop_t accum(input int i, input bit first, input bit dbl);
        slot_t k, s;
        k = (i == 0 || i == 3) ? R_KX : (i == 1 || i == 4) ? R_KY : R_KZ;
        s = (i == 0 || i == 3) ? R_SX : (i == 1 || i == 4) ? R_SY : R_SZ;
        if (first)
            accum = mk(OP_ADD, k, R_T1, s);    // T1 is zero here
        else if (dbl && i >= 3)
            accum = mk(OP_ADD, s, R_T0, s);
        else if (dbl)
            accum = mk(OP_ADD, k, k, R_T0);
        else
            accum = mk(OP_ADD, s, k, s);
        return accum;
    endfunction

    function automatic uop_t rk_rom(input logic [PCW-1:0] pc);
        int p;
        int q;
        int j;
        slot_t s, d;
        p = int'(pc);
        if (p < 8)        rk_rom = deriv(p, R_X, R_Y, R_Z);
        else if (p == 8)  rk_rom = mk(OP_SUB, R_T1, R_T1, R_T1);
        else if (p < 12)  rk_rom = accum(p - 9, 1'b1, 1'b0);
        else if (p < 18)  rk_rom = midpt(p - 12, R_H);
        else if (p < 26)  rk_rom = deriv(p - 18, R_AX, R_AY, R_AZ);
        else if (p < 32)  rk_rom = accum((p - 26) / 2 + ((p - 26) % 2) * 3, 1'b0, 1'b1);
        else if (p < 38)  rk_rom = midpt(p - 32, R_H);
        else if (p < 46)  rk_rom = deriv(p - 38, R_AX, R_AY, R_AZ);
        else if (p < 52)  rk_rom = accum((p - 46) / 2 + ((p - 46) % 2) * 3, 1'b0, 1'b1);
        else if (p < 58)  rk_rom = midpt(p - 52, R_DT);
        else if (p < 66)  rk_rom = deriv(p - 58, R_AX, R_AY, R_AZ);
        else if (p < 69)  rk_rom = accum(p - 66, 1'b0, 1'b0);
        else begin
            // per axis: T0 = dt*S, T0 = T0/6, pos += T0
            q = p - 69;
            j = (q < 3) ? 0 : (q < 6) ? 1 : 2;
            s = (j == 0) ? R_SX : (j == 1) ? R_SY : R_SZ;
            d = (j == 0) ? R_X : (j == 1) ? R_Y : R_Z;
            case (q - 3 * j)
                0:       rk_rom = mk(OP_MUL, R_DT, s, R_T0);
                1:       rk_rom = mk(OP_DIV6, R_T0, R_T0, R_T0);
                default: rk_rom = mk(OP_ADD, d, R_T0, d);
            endcase
        end
    endfunction

    function automatic uop_t euler_rom(input logic [PCW-1:0] pc);
        int p;
        p = int'(pc);
        case (p)
            0:  euler_rom = mk(OP_SUB, R_Y, R_X, R_T0);
            1:  euler_rom = mk(OP_MUL, R_SIG, R_T0, R_T0);
            2:  euler_rom = mk(OP_MUL, R_DT, R_T0, R_T0);
            3:  euler_rom = mk(OP_ADD, R_X, R_T0, R_X);
            4:  euler_rom = mk(OP_SUB, R_RHO, R_Z, R_T0);
            5:  euler_rom = mk(OP_MUL, R_X, R_T0, R_T0);
            6:  euler_rom = mk(OP_SUB, R_T0, R_Y, R_T0);
            7:  euler_rom = mk(OP_MUL, R_DT, R_T0, R_T0);
            8:  euler_rom = mk(OP_ADD, R_Y, R_T0, R_Y);
            9:  euler_rom = mk(OP_MUL, R_X, R_Y, R_T0);
            10: euler_rom = mk(OP_MUL, R_BETA, R_Z, R_T1);
            11: euler_rom = mk(OP_SUB, R_T0, R_T1, R_T0);
            12: euler_rom = mk(OP_MUL, R_DT, R_T0, R_T0);
            13: euler_rom = mk(OP_ADD, R_Z, R_T0, R_Z);
            default: euler_rom = mk(OP_ADD, R_X, R_T1, R_T1);
        endcase
    endfunction

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WB,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [PCW-1:0]    pc_reg;
    logic              rk_reg;
    logic signed [W-1:0] rf_reg [NREG];
    logic              method_reg;
    logic [DT_WIDTH-1:0] dt_cfg_reg;
    logic [IO_WIDTH-1:0] steps_reg;
    uop_t              uop;
    uop_t              cur_reg;
    logic signed [W-1:0] alu_res;
    logic [PCW-1:0]    last_pc;
    logic signed [W-1:0] dt_sat;

    assign uop     = rk_reg ? rk_rom(pc_reg) : euler_rom(pc_reg);
    assign last_pc = rk_reg ? PCW'(RK_LEN - 1) : PCW'(EULER_LEN - 1);

    always_comb
    begin
        if (W > DT_WIDTH)
            dt_sat = W'({1'b0, dt_cfg_reg});
        else if ({1'b0, dt_cfg_reg} > (DT_WIDTH+1)'(VMAX))
            dt_sat = VMAX;
        else
            dt_sat = W'({1'b0, dt_cfg_reg});
    end

    lsi_alu #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .clk    (clk),
        .op     (uop.op),
        .a      (rf_reg[uop.sa]),
        .b      (rf_reg[uop.sb]),
        .result (alu_res)
    );

    assign in_ready  = (state_reg == S_IDLE) && !out_valid;
    assign cfg_ready = 1'b1;
    assign x_out     = IO_WIDTH'(rf_reg[R_X]);
    assign y_out     = IO_WIDTH'(rf_reg[R_Y]);
    assign z_out     = IO_WIDTH'(rf_reg[R_Z]);
    assign step_count = steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            rk_reg     <= 1'b0;
            out_valid  <= 1'b0;
            method_reg <= 1'b1;
            dt_cfg_reg <= DT_RESET;
            steps_reg  <= '0;
            cur_reg    <= mk(OP_ADD, R_X, R_X, R_X);
            for (int i = 0; i < NREG; i++)
                rf_reg[i] <= (i == int'(R_SIG))  ? sat_in(SIGMA_RESET) :
                             (i == int'(R_RHO))  ? sat_in(RHO_RESET) :
                             (i == int'(R_BETA)) ? sat_in(BETA_RESET) : '0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SIGMA:  rf_reg[R_SIG]  <= sat_in(cfg_data);
                    REG_RHO:    rf_reg[R_RHO]  <= sat_in(cfg_data);
                    REG_BETA:   rf_reg[R_BETA] <= sat_in(cfg_data);
                    REG_DT:     dt_cfg_reg     <= cfg_data[DT_WIDTH-1:0];
                    REG_METHOD: method_reg     <= cfg_data[0];
                    default:    ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (!mode)
                        begin
                            rf_reg[R_X] <= sat_in(x_in);
                            rf_reg[R_Y] <= sat_in(y_in);
                            rf_reg[R_Z] <= sat_in(z_in);
                            steps_reg   <= '0;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            rf_reg[R_DT] <= dt_sat;
                            rf_reg[R_H]  <= dt_sat >>> 1;
                            rk_reg       <= method_reg;
                            pc_reg       <= '0;
                            state_reg    <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    cur_reg   <= uop;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    rf_reg[cur_reg.dst] <= alu_res;
                    if (pc_reg == last_pc)
                    begin
                        if (steps_reg != {IO_WIDTH{1'b1}})
                            steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_ISSUE;
                    end
                end
                S_OUT:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid) else $error("result not posted");
    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (pc_reg <= last_pc)) else $error("pc overrun");
`endif

endmodule
`default_nettype wire

// File: rtl/lsi_alu.sv
`default_nettype none
// Shared saturating unit: add, subtract, fixed-point multiply, divide by six.
// Divide by six reuses the multiplier: magnitude times a reciprocal constant,
// then the sign is put back, so the quotient truncates toward zero.
// Every result, multiplier and divider included, is registered; it is valid in the cycle after the operands.
module lsi_alu #(
    parameter int VALUE_WIDTH   = lsi_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = lsi_pkg::FRACTION_BITS_DEF
) (
    input  wire                             clk,
    input  wire lsi_pkg::alu_op_t           op,
    input  wire logic signed [VALUE_WIDTH-1:0] a,
    input  wire logic signed [VALUE_WIDTH-1:0] b,
    output logic signed [VALUE_WIDTH-1:0]   result
);
    import lsi_pkg::*;

    localparam int PW = 2 * VALUE_WIDTH;
    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    // ceil(2^(W+1) / 3); quotient = (|a| * RECIP6) >> (W+2), exact for |a| <= 2^(W-1)
    localparam logic [VALUE_WIDTH-1:0] RECIP6 = VALUE_WIDTH'(
        ({1'b1, {(VALUE_WIDTH+1){1'b0}}} + (VALUE_WIDTH+2)'(2)) / (VALUE_WIDTH+2)'(3));

    logic signed [VALUE_WIDTH:0]   sum;
    logic [VALUE_WIDTH-1:0]        mag;
    logic signed [VALUE_WIDTH:0]   mul_a;
    logic signed [VALUE_WIDTH:0]   mul_b;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          shifted;
    logic signed [VALUE_WIDTH-1:0] add_sat;
    logic signed [VALUE_WIDTH-1:0] mul_sat;
    logic [VALUE_WIDTH-1:0]        q_mag;
    logic signed [VALUE_WIDTH-1:0] div_q;
    logic signed [VALUE_WIDTH-1:0] result_next;

    always_comb
    begin
        if (op == OP_SUB)
            sum = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        else
            sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1])
            add_sat = sum[VALUE_WIDTH] ? VMIN : VMAX;
        else
            add_sat = sum[VALUE_WIDTH-1:0];

        mag = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
        if (op == OP_DIV6)
        begin
            mul_a = {1'b0, mag};
            mul_b = {1'b0, RECIP6};
        end
        else
        begin
            mul_a = {a[VALUE_WIDTH-1], a};
            mul_b = {b[VALUE_WIDTH-1], b};
        end

        prod    = mul_a * mul_b;
        shifted = prod >>> FRACTION_BITS;
        if (shifted > PW'(VMAX))
            mul_sat = VMAX;
        else if (shifted < PW'(VMIN))
            mul_sat = VMIN;
        else
            mul_sat = shifted[VALUE_WIDTH-1:0];

        // truncating divide by six
        q_mag = {2'b00, prod[PW-1:VALUE_WIDTH+2]};
        div_q = a[VALUE_WIDTH-1] ? (~q_mag + 1'b1) : q_mag;

        unique case (op)
            OP_ADD, OP_SUB: result_next = add_sat;
            OP_MUL:         result_next = mul_sat;
            OP_DIV6:        result_next = div_q;
            default:        result_next = add_sat;
        endcase
    end

    always_ff @(posedge clk)
    begin
        result <= result_next;
    end

endmodule
`default_nettype wire

// File: sim/lorenz_system_integrator_unit_test.sv
`default_nettype none
// Block-level test of the Lorenz integrator.
// The model below tracks state and registers in 64-bit signed math and
// clamps back to 32 bits after every product and sum. Expected words are
// queued at input accept and compared at output accept.
module lorenz_system_integrator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lsi_pkg::*;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;
    localparam logic METHOD_EULER = 1'b0;
    localparam logic METHOD_RK4   = 1'b1;
    localparam int   FRAC = 22;
    localparam int   WATCHDOG_LIMIT = 6000;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        count;
    } state_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = MODE_LOAD;
    logic signed [31:0] x_in = '0, y_in = '0, z_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] x_out, y_out, z_out;
    logic [31:0] step_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #5 clk = ~clk;

    lorenz_system_integrator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .x_in(x_in), .y_in(y_in), .z_in(z_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .x_out(x_out), .y_out(y_out), .z_out(z_out), .step_count(step_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------- model of the integrator ----------------
    longint m_sigma, m_rho, m_beta, m_dt;
    logic   m_method;
    longint pos_x, pos_y, pos_z;
    logic [31:0] steps;

    state_word_t expected_words[$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_stall = 1'b0;   // stretches with the receiver always ready

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q10.22 product, floor shift, then saturate (32x32 fits in 64 bits)
    function automatic longint qmul(longint a, longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clamp32(a - b);
    endfunction

    function automatic longint deriv_x(longint x, longint y, longint z);
        return qmul(m_sigma, qsub(y, x));
    endfunction

    function automatic longint deriv_y(longint x, longint y, longint z);
        return qsub(qmul(x, qsub(m_rho, z)), y);
    endfunction

    function automatic longint deriv_z(longint x, longint y, longint z);
        return qsub(qmul(x, y), qmul(m_beta, z));
    endfunction

    // weighted RK4 sum, scaled by dt; divide truncates toward zero
    function automatic longint rk_delta(longint k1, longint k2, longint k3, longint k4);
        longint s;
        s = qadd(qadd(qadd(k1, qadd(k2, k2)), qadd(k3, k3)), k4);
        return qmul(m_dt, s) / 6;
    endfunction

    task automatic advance_state();
        longint x, y, z, h, ax, ay, az;
        longint k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
        x = pos_x; y = pos_y; z = pos_z;
        if (m_method == METHOD_EULER) begin
            // sequential update: y sees new x, z sees new x and y
            x = qadd(x, qmul(m_dt, deriv_x(x, y, z)));
            y = qadd(y, qmul(m_dt, deriv_y(x, y, z)));
            z = qadd(z, qmul(m_dt, deriv_z(x, y, z)));
        end
        else begin
            h = m_dt >>> 1;
            k1x = deriv_x(x, y, z); k1y = deriv_y(x, y, z); k1z = deriv_z(x, y, z);
            ax = qadd(x, qmul(h, k1x)); ay = qadd(y, qmul(h, k1y));
            az = qadd(z, qmul(h, k1z));
            k2x = deriv_x(ax, ay, az); k2y = deriv_y(ax, ay, az); k2z = deriv_z(ax, ay, az);
            ax = qadd(x, qmul(h, k2x)); ay = qadd(y, qmul(h, k2y));
            az = qadd(z, qmul(h, k2z));
            k3x = deriv_x(ax, ay, az); k3y = deriv_y(ax, ay, az); k3z = deriv_z(ax, ay, az);
            ax = qadd(x, qmul(m_dt, k3x)); ay = qadd(y, qmul(m_dt, k3y));
            az = qadd(z, qmul(m_dt, k3z));
            k4x = deriv_x(ax, ay, az); k4y = deriv_y(ax, ay, az); k4z = deriv_z(ax, ay, az);
            x = qadd(x, rk_delta(k1x, k2x, k3x, k4x));
            y = qadd(y, rk_delta(k1y, k2y, k3y, k4y));
            z = qadd(z, rk_delta(k1z, k2z, k3z, k4z));
        end
        pos_x = x; pos_y = y; pos_z = z;
        if (steps != 32'hFFFF_FFFF) steps = steps + 32'd1;
    endtask

    task automatic apply_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
        case (idx)
            REG_SIGMA:  m_sigma = longint'(signed'(data));
            REG_RHO:    m_rho   = longint'(signed'(data));
            REG_BETA:   m_beta  = longint'(signed'(data));
            REG_DT:     m_dt    = longint'(data[DT_WIDTH-1:0]);
            REG_METHOD: m_method = data[0];
            default: ;
        endcase
    endtask

    // ---------------- monitors ----------------
    always @(posedge clk) begin
        state_word_t w, got;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (in_valid && in_ready) begin
                if (mode == MODE_LOAD) begin
                    pos_x = longint'(x_in);
                    pos_y = longint'(y_in);
                    pos_z = longint'(z_in);
                    steps = '0;
                end
                else
                    advance_state();
                w.x = pos_x[31:0]; w.y = pos_y[31:0]; w.z = pos_z[31:0];
                w.count = steps;
                expected_words.push_back(w);
            end
            if (out_valid && out_ready) begin
                got = '{x_out, y_out, z_out, step_count};
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else begin
                    w = expected_words.pop_front();
                    if (got.x !== w.x) begin
                        $error("x_out: expected %0d actual %0d", w.x, got.x); errors++;
                    end
                    if (got.y !== w.y) begin
                        $error("y_out: expected %0d actual %0d", w.y, got.y); errors++;
                    end
                    if (got.z !== w.z) begin
                        $error("z_out: expected %0d actual %0d", w.z, got.z); errors++;
                    end
                    if (got.count !== w.count) begin
                        $error("step_count: expected %0d actual %0d", w.count, got.count);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure, with occasional no-stall stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0) no_stall <= ~no_stall;
        if (no_stall) out_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;   // rare long stall start
        else if (!out_ready && $urandom_range(0, 99) < 10) out_ready <= 1'b1;
        else if (out_ready) out_ready <= ($urandom_range(0, 99) < 75);
        else out_ready <= 1'b0;
    end

    // watchdog: cycles with no accepted word on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- shared drivers ----------------
    task automatic send_word(logic m, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m; x_in <= x; y_in <= y; z_in <= z;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop sending and let every expected word come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_params(logic [31:0] s, logic [31:0] r, logic [31:0] b,
                              logic [31:0] dt, logic meth);
        write_reg(REG_SIGMA, s);
        write_reg(REG_RHO, r);
        write_reg(REG_BETA, b);
        write_reg(REG_DT, dt);
        write_reg(REG_METHOD, {31'd0, meth});
    endtask

    function automatic logic [31:0] small_q();
        return $urandom_range(0, 32'h0A00_0000) - 32'h0500_0000;   // about +-20
    endfunction

    // ---------------- tests ----------------
    // first steps run under the reset register values (RK4 from origin)
    task automatic test_reset_defaults();
        send_word(MODE_STEP, '0, '0, '0);
        send_word(MODE_LOAD, 32'h0040_0000, 32'h0040_0000, 32'h0040_0000);
        repeat (3) send_word(MODE_STEP, $urandom, $urandom, $urandom);
        drain();
    endtask

    // load extremes of each field, then step so products saturate
    task automatic test_load_extremes();
        send_word(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(MODE_STEP, '0, '0, '0);
        send_word(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(MODE_STEP, '0, '0, '0);
        send_word(MODE_LOAD, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_word(MODE_STEP, '0, '0, '0);
        drain();
    endtask

    task automatic test_euler();
        set_params(32'h0280_0000, 32'h0700_0000, 32'h00AA_AAAA, 32'd41943, METHOD_EULER);
        send_word(MODE_LOAD, 32'h0040_0000, 32'h0080_0000, 32'hFFC0_0000);
        repeat (4) send_word(MODE_STEP, '0, '0, '0);
        drain();
    endtask

    // register extremes: dt zero, dt one, all dt bits set, parameter limits
    task automatic test_register_extremes();
        set_params(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, METHOD_RK4);
        send_word(MODE_LOAD, 32'h0100_0000, 32'hFF00_0000, 32'h0200_0000);
        send_word(MODE_STEP, '0, '0, '0);
        drain();
        set_params(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0040_0000, METHOD_RK4);
        send_word(MODE_STEP, '0, '0, '0);
        send_word(MODE_STEP, '0, '0, '0);
        drain();
        // upper bits of dt data ignored; index past the list ignored
        write_reg(REG_DT, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        write_reg(REG_METHOD, 32'hFFFF_FFFE);
        send_word(MODE_LOAD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_word(MODE_STEP, '0, '0, '0);
        drain();
    endtask

    // well-formed runs: load, then a burst of steps; some raw noise loads and register settings
    task automatic test_random_runs(int total);
        int sent, n;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(0, 3) == 0) begin
                drain();
                if ($urandom_range(0, 4) == 0)
                    set_params($urandom, $urandom, $urandom, $urandom,
                               1'($urandom_range(0, 1)));
                else
                    set_params(32'h0280_0000 + $urandom_range(0, 32'h0040_0000),
                               32'h0700_0000 - $urandom_range(0, 32'h0100_0000),
                               32'h00AA_AAAA, $urandom_range(0, 23'd100000),
                               1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) == 0)
                send_word(MODE_LOAD, $urandom, $urandom, $urandom);
            else
                send_word(MODE_LOAD, small_q(), small_q(), small_q() + 32'h0500_0000);
            n = $urandom_range(2, 12);
            repeat (n) send_word(MODE_STEP, $urandom, $urandom, $urandom);
            sent += n + 1;
        end
        drain();
    endtask

    initial begin
        m_sigma = 41943040; m_rho = 117440512; m_beta = 11184810;
        m_dt = 41943; m_method = METHOD_RK4;
        pos_x = 0; pos_y = 0; pos_z = 0; steps = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_load_extremes();
        test_euler();
        test_register_extremes();
        test_random_runs(400);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
